### src/positional_list_store_assert.svh
// ----------------------------------------------------------------------------
// positional list store assertion macros
// concurrent checks on the rising clock edge, disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define PLS_ASSERT_NOW(name, cond, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define PLS_ASSERT_NEXT(name, cond, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

### src/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// shared codes, field widths and transfer types of the positional list store
// ----------------------------------------------------------------------------
package pls_pkg;

   // field widths
   localparam int OP_W   = 3;
   localparam int ELEM_W = 32;
   localparam int POS_W  = 5;
   localparam int CNT_W  = 5;
   localparam int ST_W   = 2;
   localparam int ACT_W  = 3;

   // default sizing
   localparam int DEPTH_DEF       = 16;
   localparam int VALUE_WIDTH_DEF = 32;

   // operation codes
   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
   localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
   localparam logic [OP_W-1:0] OP_DUMP      = 3'd6;

   // status codes
   localparam logic [ST_W-1:0] ST_OK     = 2'd0;
   localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
   localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

   // actions chosen by the planner
   localparam logic [ACT_W-1:0] ACT_NONE        = 3'd0;
   localparam logic [ACT_W-1:0] ACT_PUT_DIRECT  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_PUT_SHIFT   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_TAKE_DIRECT = 3'd3;
   localparam logic [ACT_W-1:0] ACT_TAKE_SHIFT  = 3'd4;
   localparam logic [ACT_W-1:0] ACT_DUMP        = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [ELEM_W-1:0] value;
      logic [POS_W-1:0]         position;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]          status;
      logic signed [ELEM_W-1:0] element;
      logic [CNT_W-1:0]         count;
      logic                     last;
   } rsp_type;

   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [ACT_W-1:0] action;
   } plan_type;

endpackage

### src/pls_plan.sv
// ----------------------------------------------------------------------------
// pls_plan
// checks an operation against the fill level and picks the action and index
// ----------------------------------------------------------------------------
module pls_plan #(
   parameter int DEPTH = pls_pkg::DEPTH_DEF
) (
   input  logic [pls_pkg::OP_W-1:0]  op,
   input  logic [pls_pkg::POS_W-1:0] position,
   input  logic [$clog2(DEPTH+1)-1:0] fill,
   output pls_pkg::plan_type         plan,
   output logic [$clog2(DEPTH)-1:0]  idx
);
   import pls_pkg::*;

   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CMP_W  = ((FILL_W > POS_W) ? FILL_W : POS_W) + 1;

   logic [CMP_W-1:0] fill_x;
   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] target;
   logic             full;
   logic             empty;

   assign fill_x = CMP_W'(fill);
   assign pos_x  = CMP_W'(position);
   assign full   = (fill_x >= CMP_W'(DEPTH));
   assign empty  = (fill_x == '0);
   assign idx    = IDX_W'(target);

   // status and action per operation, full and empty checked before position
   always_comb begin
      plan.status = ST_OK;
      plan.action = ACT_NONE;
      target      = '0;
      unique case (op)
         OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
            if (op == OP_INS_BACK) begin
               target = fill_x;
            end else if (op == OP_INS_AT) begin
               target = pos_x - CMP_W'(1);
            end
            if (full) begin
               plan.status = ST_FULL;
            end else if ((op == OP_INS_AT) && ((pos_x == '0) || (pos_x > fill_x + CMP_W'(1)))) begin
               plan.status = ST_BADPOS;
            end else if (target == fill_x) begin
               plan.action = ACT_PUT_DIRECT;
            end else begin
               plan.action = ACT_PUT_SHIFT;
            end
         end
         OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
            if (op == OP_DEL_BACK) begin
               target = fill_x - CMP_W'(1);
            end else if (op == OP_DEL_AT) begin
               target = pos_x - CMP_W'(1);
            end
            if (empty) begin
               plan.status = ST_EMPTY;
            end else if ((op == OP_DEL_AT) && ((pos_x == '0) || (pos_x > fill_x))) begin
               plan.status = ST_BADPOS;
            end else if (target == fill_x - CMP_W'(1)) begin
               plan.action = ACT_TAKE_DIRECT;
            end else begin
               plan.action = ACT_TAKE_SHIFT;
            end
         end
         OP_DUMP: begin
            if (empty) begin
               plan.status = ST_EMPTY;
            end else begin
               plan.action = ACT_DUMP;
            end
         end
         default: begin
            // unused code: answer with the unchanged count
            plan.status = ST_OK;
         end
      endcase
   end

endmodule

### src/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store
// bounded ordered list of signed values in one synchronous memory, with
// insert and delete at front, back or a 1-based position, and an ordered dump
// ----------------------------------------------------------------------------
//  channel   ports                          direction  transfer
//  request   start, busy, req_item          in         start high, busy low
//  response  rsp_strobe, rsp_item           out        rsp_strobe high
//
//  updates at the back end (including the first insert and the last delete)
//  and refused or spare operations: result in the cycle after the transfer.
//  shifting insert/delete: busy while the moved entries are read and rewritten.
//  dump: busy until the last entry is sent; each entry passes the memory read
//  register and the result register, then one result per cycle.
//  reset clears the control registers, not the memory; results cannot be stalled.
// ----------------------------------------------------------------------------
module positional_list_store #(
   parameter int DEPTH       = pls_pkg::DEPTH_DEF,
   parameter int VALUE_WIDTH = pls_pkg::VALUE_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pls_pkg::req_type req_item,
   output logic             rsp_strobe,
   output pls_pkg::rsp_type rsp_item
);
   import pls_pkg::*;

   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int IDX_W  = $clog2(DEPTH);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_UP   = 2'd1;
   localparam logic [1:0] S_DOWN = 2'd2;
   localparam logic [1:0] S_DUMP = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [IDX_W-1:0]       src_ff, src_in;
   logic [IDX_W-1:0]       end_ff, end_in;
   logic [IDX_W-1:0]       wr_ff, wr_in;
   logic                   iss_ff, iss_in;
   logic                   pend_ff, pend_in;
   logic                   lastrd_ff, lastrd_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rsp_type                rsp_ff, rsp_in;

   logic [VALUE_WIDTH-1:0] mem_ff [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;

   plan_type               plan;
   logic [IDX_W-1:0]       plan_idx;
   logic [VALUE_WIDTH-1:0] store_val;

   // operation check against the current fill level
   pls_plan #(
      .DEPTH (DEPTH)
   ) u_plan (
      .op       (req_item.op),
      .position (req_item.position),
      .fill     (fill_ff),
      .plan     (plan),
      .idx      (plan_idx)
   );

   assign store_val  = VALUE_WIDTH'($unsigned(req_item.value));
   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // sequencer: shifts run as a read pipeline with writes in the cycle after their reads
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      src_in        = src_ff;
      end_in        = end_ff;
      wr_in         = wr_ff;
      iss_in        = iss_ff;
      pend_in       = 1'b0;
      lastrd_in     = lastrd_ff;
      val_in        = val_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      rd_addr       = src_ff;
      wr_en         = 1'b0;
      wr_addr       = wr_ff;
      wr_data       = rd_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (plan.action)
                  ACT_NONE: begin
                     rsp_strobe_in = 1'b1;
                  end
                  ACT_PUT_DIRECT: begin
                     wr_en         = 1'b1;
                     wr_addr       = plan_idx;
                     wr_data       = store_val;
                     fill_in       = fill_ff + FILL_W'(1);
                     rsp_strobe_in = 1'b1;
                  end
                  ACT_PUT_SHIFT: begin
                     src_in   = IDX_W'(fill_ff - FILL_W'(1));
                     end_in   = plan_idx;
                     iss_in   = 1'b1;
                     val_in   = store_val;
                     state_in = S_UP;
                  end
                  ACT_TAKE_DIRECT: begin
                     fill_in       = fill_ff - FILL_W'(1);
                     rsp_strobe_in = 1'b1;
                  end
                  ACT_TAKE_SHIFT: begin
                     src_in   = plan_idx + IDX_W'(1);
                     end_in   = IDX_W'(fill_ff - FILL_W'(1));
                     iss_in   = 1'b1;
                     state_in = S_DOWN;
                  end
                  ACT_DUMP: begin
                     src_in   = '0;
                     end_in   = IDX_W'(fill_ff - FILL_W'(1));
                     iss_in   = 1'b1;
                     state_in = S_DUMP;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
               rsp_in.status  = plan.status;
               rsp_in.element = '0;
               rsp_in.last    = 1'b1;
            end
         end
         S_UP: begin
            // move entries up one place, from the back towards the position
            if (pend_ff) begin
               wr_en = 1'b1;
            end else if (!iss_ff) begin
               wr_en          = 1'b1;
               wr_addr        = end_ff;
               wr_data        = val_ff;
               fill_in        = fill_ff + FILL_W'(1);
               rsp_strobe_in  = 1'b1;
               rsp_in.status  = ST_OK;
               rsp_in.element = '0;
               rsp_in.last    = 1'b1;
               state_in       = S_IDLE;
            end
            if (iss_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               wr_in   = src_ff + IDX_W'(1);
               if (src_ff == end_ff) begin
                  iss_in = 1'b0;
               end else begin
                  src_in = src_ff - IDX_W'(1);
               end
            end
         end
         S_DOWN: begin
            // move entries down one place, from the position towards the back
            if (pend_ff) begin
               wr_en = 1'b1;
               if (!iss_ff) begin
                  fill_in        = fill_ff - FILL_W'(1);
                  rsp_strobe_in  = 1'b1;
                  rsp_in.status  = ST_OK;
                  rsp_in.element = '0;
                  rsp_in.last    = 1'b1;
                  state_in       = S_IDLE;
               end
            end
            if (iss_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               wr_in   = src_ff - IDX_W'(1);
               if (src_ff == end_ff) begin
                  iss_in = 1'b0;
               end else begin
                  src_in = src_ff + IDX_W'(1);
               end
            end
         end
         S_DUMP: begin
            // one element read per cycle, emitted the cycle after
            if (pend_ff) begin
               rsp_strobe_in  = 1'b1;
               rsp_in.status  = ST_OK;
               rsp_in.element = ELEM_W'($signed(rd_data_ff));
               rsp_in.last    = lastrd_ff;
               if (lastrd_ff) begin
                  state_in = S_IDLE;
               end
            end
            if (iss_ff) begin
               rd_en     = 1'b1;
               pend_in   = 1'b1;
               lastrd_in = (src_ff == end_ff);
               iss_in    = (src_ff != end_ff);
               src_in    = src_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (rsp_strobe_in) begin
         rsp_in.count = CNT_W'(fill_in);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         iss_ff        <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         iss_ff        <= iss_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      src_ff    <= src_in;
      end_ff    <= end_in;
      wr_ff     <= wr_in;
      lastrd_ff <= lastrd_in;
      val_ff    <= val_in;
      rsp_ff    <= rsp_in;
   end

   // element memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   `include "positional_list_store_assert.svh"

   `PLS_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= FILL_W'(DEPTH), "fill beyond depth")
   `PLS_ASSERT_NOW(a_port_clash, rd_en && wr_en, rd_addr != wr_addr, "read and write same entry")
   `PLS_ASSERT_NOW(a_up_room, state_ff == S_UP, fill_ff < FILL_W'(DEPTH), "shift up on full list")
   `PLS_ASSERT_NOW(a_rsp_cause, rsp_strobe, $past(start && !busy) || $past(state_ff != S_IDLE), "result without work")

endmodule
